FILE: design/aml_name_string_parser_unit_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef AML_NAME_STRING_PARSER_UNIT_MACROS_SVH
`define AML_NAME_STRING_PARSER_UNIT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define AML_NSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define AML_NSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/aml_nsp_pkg.sv
`timescale 1ns / 1ps

package aml_nsp_pkg;

    // Special bytes of the AML name encoding.
    localparam logic [7:0] ROOT_BYTE   = 8'h5C;
    localparam logic [7:0] PARENT_BYTE = 8'h5E;
    localparam logic [7:0] DUAL_BYTE   = 8'h2E;
    localparam logic [7:0] MULTI_BYTE  = 8'h2F;
    localparam logic [7:0] NULL_BYTE   = 8'h00;

    // Parser phase codes.
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PARENTS = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PATHLEN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SEG     = 3'd4;

    // Error codes.
    localparam logic ERR_NONE     = 1'b0;
    localparam logic ERR_BAD_CHAR = 1'b1;

    // One result transaction.
    typedef struct packed {
        logic [31:0] segment_value;
        logic [7:0]  segment_index;
        logic [7:0]  segment_total;
        logic [7:0]  parent_count;
        logic        is_absolute;
        logic        last_of_path;
        logic        error_code;
    } result_t;

    // First character of a name segment: 'A'-'Z' or '_'.
    function automatic logic lead_ok(input logic [7:0] c);
        lead_ok = ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
    endfunction

    // Other characters may also be digits.
    function automatic logic char_ok(input logic [7:0] c);
        char_ok = lead_ok(c) || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    // Whole segment check, first character in the low byte.
    function automatic logic word_ok(input logic [31:0] w);
        word_ok = lead_ok(w[7:0]) && char_ok(w[15:8]) &&
                  char_ok(w[23:16]) && char_ok(w[31:24]);
    endfunction

endpackage

FILE: design/aml_name_string_parser_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     data_valid / data_ready    data_byte
// result    result_valid / result_ready segment_value, segment_index, segment_total,
//                                      parent_count, is_absolute, last_of_path, error_code
//
// One byte is accepted per cycle while data_ready is high; a byte is decoded from the input register.
// A result passes through the input register and then the result register before it shows on the ports.
// Decode is combinational between the input and result registers.
// Reset is asynchronous, active low, and returns the parser to idle with no path held.
// A stalled result blocks decoding; one more byte can still wait in the input register.

module aml_name_string_parser_unit
    import aml_nsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] segment_value,
    output logic [7:0]  segment_index,
    output logic [7:0]  segment_total,
    output logic [7:0]  parent_count,
    output logic        is_absolute,
    output logic        last_of_path,
    output logic        error_code
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       step;
    logic       emit;
    result_t    parsed;
    result_t    out_data;

    // The decode stage may run whenever the result register can take a value.
    assign advance    = !result_valid || result_ready;
    assign step       = in_valid_reg && advance;
    assign data_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (data_valid && data_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            in_byte_reg <= data_byte;
        end
    end

    // Byte decode and parse state.
    aml_nsp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .emit    (emit),
        .result  (parsed)
    );

    // Result register.
    aml_nsp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_data (parsed),
        .take      (result_ready),
        .valid     (result_valid),
        .data      (out_data)
    );

    assign segment_value = out_data.segment_value;
    assign segment_index = out_data.segment_index;
    assign segment_total = out_data.segment_total;
    assign parent_count  = out_data.parent_count;
    assign is_absolute   = out_data.is_absolute;
    assign last_of_path  = out_data.last_of_path;
    assign error_code    = out_data.error_code;

endmodule

FILE: design/aml_nsp_parser.sv
`timescale 1ns / 1ps

module aml_nsp_parser
    import aml_nsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  byte_in,
    output logic        emit,
    output result_t     result
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         parent_reg, parent_next;
    logic               abs_reg, abs_next;
    logic [7:0]         segs_reg, segs_next;
    logic [7:0]         segcnt_reg, segcnt_next;
    logic [1:0]         pos_reg, pos_next;
    logic [31:0]        acc_reg, acc_next;

    logic        go_pathlen;
    logic        go_seg;
    logic        go_empty;
    logic        go_clear;
    logic [31:0] word;
    logic        last_seg;

    // Segment word with the current byte placed at its position.
    always_comb
    begin
        case (pos_reg)
            2'd0:    word = {acc_reg[31:8], byte_in};
            2'd1:    word = {acc_reg[31:16], byte_in, acc_reg[7:0]};
            2'd2:    word = {acc_reg[31:24], byte_in, acc_reg[15:0]};
            2'd3:    word = {byte_in, acc_reg[23:0]};
            default: word = acc_reg;
        endcase
    end

    assign last_seg = ({1'b0, segcnt_reg} + 9'd1) >= {1'b0, segs_reg};

    // Next-state and result decode for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        parent_next = parent_reg;
        abs_next    = abs_reg;
        segs_next   = segs_reg;
        segcnt_next = segcnt_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        go_pathlen  = 1'b0;
        go_seg      = 1'b0;
        go_empty    = 1'b0;
        go_clear    = 1'b0;
        emit        = 1'b0;
        result      = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (byte_in == ROOT_BYTE)
                begin
                    abs_next   = 1'b1;
                    phase_next = PH_PATHLEN;
                end
                else if (byte_in == PARENT_BYTE)
                begin
                    parent_next = 8'd1;
                    phase_next  = PH_PARENTS;
                end
                else
                begin
                    go_pathlen = 1'b1;
                end
            end
            PH_PARENTS:
            begin
                if (byte_in == PARENT_BYTE)
                begin
                    if (parent_reg != 8'hFF)
                    begin
                        parent_next = parent_reg + 8'd1;
                    end
                end
                else
                begin
                    go_pathlen = 1'b1;
                end
            end
            PH_PATHLEN:
            begin
                go_pathlen = 1'b1;
            end
            PH_COUNT:
            begin
                if (byte_in == NULL_BYTE)
                begin
                    go_empty = 1'b1;
                end
                else
                begin
                    segs_next   = byte_in;
                    segcnt_next = 8'd0;
                    pos_next    = 2'd0;
                    acc_next    = 32'd0;
                    phase_next  = PH_SEG;
                end
            end
            PH_SEG:
            begin
                go_seg = 1'b1;
            end
            default:
            begin
                go_clear = 1'b1;
            end
        endcase

        // Path-length byte: null, dual, multi or the first name character.
        if (go_pathlen)
        begin
            segcnt_next = 8'd0;
            pos_next    = 2'd0;
            acc_next    = 32'd0;
            if (byte_in == NULL_BYTE)
            begin
                go_empty = 1'b1;
            end
            else if (byte_in == DUAL_BYTE)
            begin
                segs_next  = 8'd2;
                phase_next = PH_SEG;
            end
            else if (byte_in == MULTI_BYTE)
            begin
                phase_next = PH_COUNT;
            end
            else
            begin
                segs_next  = 8'd1;
                acc_next   = {24'd0, byte_in};
                pos_next   = 2'd1;
                phase_next = PH_SEG;
            end
        end

        // Segment byte: collect, and check the word on its fourth byte.
        if (go_seg)
        begin
            if (pos_reg != 2'd3)
            begin
                acc_next   = word;
                pos_next   = pos_reg + 2'd1;
                phase_next = PH_SEG;
            end
            else
            begin
                emit                 = 1'b1;
                result.segment_value = word;
                result.segment_index = segcnt_reg;
                result.segment_total = segs_reg;
                result.parent_count  = parent_reg;
                result.is_absolute   = abs_reg;
                pos_next             = 2'd0;
                acc_next             = 32'd0;
                if (!word_ok(word))
                begin
                    result.last_of_path = 1'b1;
                    result.error_code   = ERR_BAD_CHAR;
                    go_clear            = 1'b1;
                end
                else
                begin
                    result.last_of_path = last_seg;
                    result.error_code   = ERR_NONE;
                    if (last_seg)
                    begin
                        go_clear = 1'b1;
                    end
                    else
                    begin
                        segcnt_next = segcnt_reg + 8'd1;
                        phase_next  = PH_SEG;
                    end
                end
            end
        end

        // Empty path gives a single result with zero segment value, index and total.
        if (go_empty)
        begin
            emit                 = 1'b1;
            result.segment_value = 32'd0;
            result.segment_index = 8'd0;
            result.segment_total = 8'd0;
            result.parent_count  = parent_reg;
            result.is_absolute   = abs_reg;
            result.last_of_path  = 1'b1;
            result.error_code    = ERR_NONE;
            go_clear             = 1'b1;
        end

        // End of the name string returns all path state to idle.
        if (go_clear)
        begin
            phase_next  = PH_IDLE;
            parent_next = 8'd0;
            abs_next    = 1'b0;
            segs_next   = 8'd0;
            segcnt_next = 8'd0;
            pos_next    = 2'd0;
            acc_next    = 32'd0;
        end

        if (!step)
        begin
            emit = 1'b0;
        end
    end

    // Parse state advances once per processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            parent_reg <= 8'd0;
            abs_reg    <= 1'b0;
            segs_reg   <= 8'd0;
            segcnt_reg <= 8'd0;
            pos_reg    <= 2'd0;
            acc_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            parent_reg <= parent_next;
            abs_reg    <= abs_next;
            segs_reg   <= segs_next;
            segcnt_reg <= segcnt_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

FILE: design/aml_nsp_out_reg.sv
`timescale 1ns / 1ps

module aml_nsp_out_reg
    import aml_nsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    input  logic    take,
    output logic    valid,
    output result_t data
);

    logic    valid_reg;
    result_t data_reg;

    // Result is held until the downstream side takes the transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: design/aml_nsp_checker.sv
`timescale 1ns / 1ps
`include "aml_name_string_parser_unit_macros.svh"

module aml_nsp_checker
    import aml_nsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] segment_value,
    input logic [7:0]  segment_index,
    input logic [7:0]  segment_total,
    input logic        last_of_path,
    input logic        error_code
);

    // No result transaction is offered while reset is held.
    `AML_NSP_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !result_valid, "result during reset")

    // A stalled result keeps its segment word.
    `AML_NSP_ASSERT(a_hold_value, result_valid && !result_ready |=> result_valid && $stable(segment_value), "stalled result changed")

    // A bad character always ends the name string.
    `AML_NSP_ASSERT(a_error_last, result_valid && (error_code == ERR_BAD_CHAR) |-> last_of_path, "error result not last")

    // A good result is an empty path or lies inside the segment count.
    `AML_NSP_ASSERT(a_index_range, result_valid && (error_code == ERR_NONE) |-> ((segment_total == 8'd0) && (segment_index == 8'd0) && (segment_value == 32'd0) && last_of_path) || (segment_index < segment_total), "segment index out of range")

    // A good result that is not last leaves at least one segment to come.
    `AML_NSP_ASSERT(a_more_to_come, result_valid && (error_code == ERR_NONE) && !last_of_path |-> (({1'b0, segment_index} + 9'd1) < {1'b0, segment_total}), "missing last mark")

endmodule

bind aml_name_string_parser_unit aml_nsp_checker u_aml_nsp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .segment_value (segment_value),
    .segment_index (segment_index),
    .segment_total (segment_total),
    .last_of_path  (last_of_path),
    .error_code    (error_code)
);
